// ===== rtl/rvdec_pkg.sv =====
// Shared types, opcode and sub-code constants and id lookup functions
// for the RV32IMF instruction decoder pipeline. No dependencies.
package rvdec_pkg;

   // Major opcodes
   localparam logic [6:0] OPC_OP      = 7'h33;
   localparam logic [6:0] OPC_OPIMM   = 7'h13;
   localparam logic [6:0] OPC_STORE   = 7'h23;
   localparam logic [6:0] OPC_BRANCH  = 7'h63;
   localparam logic [6:0] OPC_JAL     = 7'h6F;
   localparam logic [6:0] OPC_JALR    = 7'h67;
   localparam logic [6:0] OPC_LUI     = 7'h37;
   localparam logic [6:0] OPC_AUIPC   = 7'h17;
   localparam logic [6:0] OPC_LOAD    = 7'h03;
   localparam logic [6:0] OPC_LOADFP  = 7'h07;
   localparam logic [6:0] OPC_STOREFP = 7'h27;
   localparam logic [6:0] OPC_OPFP    = 7'h53;
   localparam logic [6:0] OPC_MADD    = 7'h43;
   localparam logic [6:0] OPC_MSUB    = 7'h47;
   localparam logic [6:0] OPC_NMSUB   = 7'h4B;
   localparam logic [6:0] OPC_NMADD   = 7'h4F;
   localparam logic [6:0] OPC_SYSTEM  = 7'h73;

   // Sub-codes
   localparam logic [6:0] F7_BASE   = 7'h00;
   localparam logic [6:0] F7_MULDIV = 7'h01;
   localparam logic [6:0] F7_ALT    = 7'h20;
   localparam logic [2:0] F3_ADD    = 3'd0;
   localparam logic [2:0] F3_SLL    = 3'd1;
   localparam logic [2:0] F3_SR     = 3'd5;
   localparam logic [2:0] F3_PRIV   = 3'd0;
   localparam logic [11:0] F12_ECALL  = 12'd0;
   localparam logic [11:0] F12_EBREAK = 12'd1;

   localparam logic [4:0] F5_FADD   = 5'h00;
   localparam logic [4:0] F5_FSUB   = 5'h01;
   localparam logic [4:0] F5_FMUL   = 5'h02;
   localparam logic [4:0] F5_FDIV   = 5'h03;
   localparam logic [4:0] F5_FSGNJ  = 5'h04;
   localparam logic [4:0] F5_FMINMX = 5'h05;
   localparam logic [4:0] F5_FSQRT  = 5'h0B;
   localparam logic [4:0] F5_FCMP   = 5'h14;
   localparam logic [4:0] F5_FCVTWS = 5'h18;
   localparam logic [4:0] F5_FCVTSW = 5'h1A;
   localparam logic [4:0] F5_FMVXW  = 5'h1C;
   localparam logic [4:0] F5_FMVWX  = 5'h1E;

   // Format classes
   localparam logic [4:0] CLS_NONE      = 5'd0;
   localparam logic [4:0] CLS_R         = 5'd1;
   localparam logic [4:0] CLS_I         = 5'd2;
   localparam logic [4:0] CLS_SHIFT     = 5'd3;
   localparam logic [4:0] CLS_S         = 5'd4;
   localparam logic [4:0] CLS_B         = 5'd5;
   localparam logic [4:0] CLS_J         = 5'd6;
   localparam logic [4:0] CLS_U         = 5'd7;
   localparam logic [4:0] CLS_LOAD      = 5'd8;
   localparam logic [4:0] CLS_JALR      = 5'd9;
   localparam logic [4:0] CLS_FPL       = 5'd10;
   localparam logic [4:0] CLS_FPS       = 5'd11;
   localparam logic [4:0] CLS_FPA       = 5'd12;
   localparam logic [4:0] CLS_FPR1      = 5'd13;
   localparam logic [4:0] CLS_FMINMAX   = 5'd14;
   localparam logic [4:0] CLS_FPCONVINT = 5'd15;
   localparam logic [4:0] CLS_INTCONVFP = 5'd16;
   localparam logic [4:0] CLS_FPR4      = 5'd17;
   localparam logic [4:0] CLS_ENV       = 5'd18;

   // Instruction ids
   localparam logic [6:0] ID_UNKNOWN = 7'd0;
   localparam logic [6:0] ID_ADDI = 7'd1,  ID_ANDI = 7'd2,  ID_ORI = 7'd3,   ID_XORI = 7'd4;
   localparam logic [6:0] ID_SLTI = 7'd5,  ID_SLTIU = 7'd6, ID_SLLI = 7'd7,  ID_SRLI = 7'd8;
   localparam logic [6:0] ID_SRAI = 7'd9,  ID_ADD = 7'd10,  ID_SUB = 7'd11,  ID_AND = 7'd12;
   localparam logic [6:0] ID_OR = 7'd13,   ID_XOR = 7'd14,  ID_SLL = 7'd15,  ID_SRL = 7'd16;
   localparam logic [6:0] ID_SRA = 7'd17,  ID_SLT = 7'd18,  ID_SLTU = 7'd19, ID_SB = 7'd20;
   localparam logic [6:0] ID_SH = 7'd21,   ID_SW = 7'd22,   ID_LB = 7'd23,   ID_LBU = 7'd24;
   localparam logic [6:0] ID_LH = 7'd25,   ID_LHU = 7'd26,  ID_LW = 7'd27,   ID_BEQ = 7'd28;
   localparam logic [6:0] ID_BNE = 7'd29,  ID_BLT = 7'd30,  ID_BLTU = 7'd31, ID_BGE = 7'd32;
   localparam logic [6:0] ID_BGEU = 7'd33, ID_JAL = 7'd34,  ID_JALR = 7'd35, ID_LUI = 7'd36;
   localparam logic [6:0] ID_AUIPC = 7'd37, ID_MUL = 7'd38, ID_FLW = 7'd46,  ID_FSW = 7'd47;
   localparam logic [6:0] ID_FADD = 7'd48, ID_FMUL = 7'd49, ID_FSUB = 7'd50, ID_FDIV = 7'd51;
   localparam logic [6:0] ID_FSGNJ = 7'd52, ID_FSQRT = 7'd55, ID_FMIN = 7'd56;
   localparam logic [6:0] ID_FMADD = 7'd58, ID_FCVTWS = 7'd62, ID_FMVXW = 7'd64;
   localparam logic [6:0] ID_FCVTSW = 7'd66, ID_FMVWX = 7'd68, ID_FLE = 7'd71;
   localparam logic [6:0] ID_ECALL = 7'd72, ID_EBREAK = 7'd73;

   typedef enum logic [3:0] {
      GRP_NONE, GRP_OP, GRP_OPIMM, GRP_STORE, GRP_BRANCH, GRP_JAL, GRP_JALR,
      GRP_UPPER, GRP_LOAD, GRP_LOADFP, GRP_STOREFP, GRP_OPFP, GRP_FUSED, GRP_SYSTEM
   } grp_type;

   typedef enum logic [2:0] {
      IMM_NONE, IMM_I, IMM_S, IMM_B, IMM_J, IMM_U
   } imm_sel_type;

   // Stage 1 -> stage 2
   typedef struct packed {
      logic [31:0] word;
      grp_type     grp;
   } opc_type;

   // Stage 2 -> stage 3
   typedef struct packed {
      logic [31:0] word;
      logic [6:0]  id;
      logic [4:0]  cls;
      logic        use_rd;
      logic        use_rs1;
      logic        use_rs2;
      logic        use_rs3;
      logic        use_shamt;
      logic        use_fmt;
      imm_sel_type imm_sel;
   } sub_type;

   // Decoded result
   typedef struct packed {
      logic [6:0]         op_id;
      logic [4:0]         op_class;
      logic [4:0]         dest_reg;
      logic [4:0]         src1_reg;
      logic [4:0]         src2_reg;
      logic [4:0]         src3_reg;
      logic signed [31:0] immediate;
      logic [4:0]         shift_amount;
      logic [1:0]         fp_format;
   } rsp_type;

   function automatic logic [6:0] r_base_id(input logic [2:0] f3);
      logic [6:0] id;
      case (f3)
         3'd0:    id = ID_ADD;
         3'd1:    id = ID_SLL;
         3'd2:    id = ID_SLT;
         3'd3:    id = ID_SLTU;
         3'd4:    id = ID_XOR;
         3'd5:    id = ID_SRL;
         3'd6:    id = ID_OR;
         default: id = ID_AND;
      endcase
      return id;
   endfunction

   function automatic logic [6:0] i_id(input logic [2:0] f3);
      logic [6:0] id;
      case (f3)
         3'd0:    id = ID_ADDI;
         3'd2:    id = ID_SLTI;
         3'd3:    id = ID_SLTIU;
         3'd4:    id = ID_XORI;
         3'd6:    id = ID_ORI;
         3'd7:    id = ID_ANDI;
         default: id = ID_UNKNOWN;
      endcase
      return id;
   endfunction

   function automatic logic [6:0] s_id(input logic [2:0] f3);
      logic [6:0] id;
      case (f3)
         3'd0:    id = ID_SB;
         3'd1:    id = ID_SH;
         3'd2:    id = ID_SW;
         default: id = ID_UNKNOWN;
      endcase
      return id;
   endfunction

   function automatic logic [6:0] ld_id(input logic [2:0] f3);
      logic [6:0] id;
      case (f3)
         3'd0:    id = ID_LB;
         3'd1:    id = ID_LH;
         3'd2:    id = ID_LW;
         3'd4:    id = ID_LBU;
         3'd5:    id = ID_LHU;
         default: id = ID_UNKNOWN;
      endcase
      return id;
   endfunction

   function automatic logic [6:0] b_id(input logic [2:0] f3);
      logic [6:0] id;
      case (f3)
         3'd0:    id = ID_BEQ;
         3'd1:    id = ID_BNE;
         3'd4:    id = ID_BLT;
         3'd5:    id = ID_BGE;
         3'd6:    id = ID_BLTU;
         3'd7:    id = ID_BGEU;
         default: id = ID_UNKNOWN;
      endcase
      return id;
   endfunction

endpackage

// ===== rtl/rv32imf_instruction_decoder_top.sv =====
// Top level of the RV32IMF instruction decoder: three-stage decode pipeline.
// Depends on rvdec_pkg, rvdec_opc, rvdec_sub and rvdec_out.
//
//   channel   direction  handshake            payload
//   --------  ---------  -------------------  -----------------------------------
//   request   in         start, busy          req_instr_word
//   response  out        rsp_valid (strobe)   rsp_op_id, rsp_op_class, rsp_*_reg,
//                                             rsp_immediate, rsp_shift_amount,
//                                             rsp_fp_format
//
// An item accepted at a clock edge loads the opcode group register at that
// same edge, then the sub-code match register and then the field formation
// register. rsp_valid is high for exactly one cycle per item, while its result
// sits on the rsp_ ports. One item is taken every cycle.
// Reset clears the valid bit of every stage; payload registers are left as is.
// Stalls: the receiver cannot stall, so the pipeline advances every cycle and
// busy stays low.
module rv32imf_instruction_decoder_top (
   input  logic               clock,
   input  logic               reset,
   // request
   input  logic               start,
   output logic               busy,
   input  logic [31:0]        req_instr_word,
   // response
   output logic               rsp_valid,
   output logic [6:0]         rsp_op_id,
   output logic [4:0]         rsp_op_class,
   output logic [4:0]         rsp_dest_reg,
   output logic [4:0]         rsp_src1_reg,
   output logic [4:0]         rsp_src2_reg,
   output logic [4:0]         rsp_src3_reg,
   output logic signed [31:0] rsp_immediate,
   output logic [4:0]         rsp_shift_amount,
   output logic [1:0]         rsp_fp_format
);
   import rvdec_pkg::*;

   logic    opc_valid;
   opc_type opc_data;
   logic    sub_valid;
   sub_type sub_data;
   rsp_type rsp_data;
   logic    accept;

   // The pipeline never holds, so every start is taken.
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // Stage 1: classify the major opcode
   rvdec_opc u_opc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_word   (req_instr_word),
      .out_valid (opc_valid),
      .out_data  (opc_data)
   );

   // Stage 2: match funct3 / funct7 / funct5 and pick field usage
   rvdec_sub u_sub (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (opc_valid),
      .in_data   (opc_data),
      .out_valid (sub_valid),
      .out_data  (sub_data)
   );

   // Stage 3: build immediate, zero unused fields, drive the result register
   rvdec_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sub_valid),
      .in_data   (sub_data),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   // Break the result register out onto the ports
   assign rsp_op_id        = rsp_data.op_id;
   assign rsp_op_class     = rsp_data.op_class;
   assign rsp_dest_reg     = rsp_data.dest_reg;
   assign rsp_src1_reg     = rsp_data.src1_reg;
   assign rsp_src2_reg     = rsp_data.src2_reg;
   assign rsp_src3_reg     = rsp_data.src3_reg;
   assign rsp_immediate    = rsp_data.immediate;
   assign rsp_shift_amount = rsp_data.shift_amount;
   assign rsp_fp_format    = rsp_data.fp_format;

endmodule

// ===== rtl/rvdec_opc.sv =====
// Stage 1 of the decoder: sort the major opcode into a group and register it
// with the instruction word. Depends on rvdec_pkg.
module rvdec_opc (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [31:0]         in_word,
   output logic                out_valid,
   output rvdec_pkg::opc_type  out_data
);
   import rvdec_pkg::*;

   logic    valid_ff;
   opc_type data_ff;
   opc_type data_in;

   always_comb begin
      data_in.word = in_word;
      case (in_word[6:0])
         OPC_OP:      data_in.grp = GRP_OP;
         OPC_OPIMM:   data_in.grp = GRP_OPIMM;
         OPC_STORE:   data_in.grp = GRP_STORE;
         OPC_BRANCH:  data_in.grp = GRP_BRANCH;
         OPC_JAL:     data_in.grp = GRP_JAL;
         OPC_JALR:    data_in.grp = GRP_JALR;
         OPC_LUI:     data_in.grp = GRP_UPPER;
         OPC_AUIPC:   data_in.grp = GRP_UPPER;
         OPC_LOAD:    data_in.grp = GRP_LOAD;
         OPC_LOADFP:  data_in.grp = GRP_LOADFP;
         OPC_STOREFP: data_in.grp = GRP_STOREFP;
         OPC_OPFP:    data_in.grp = GRP_OPFP;
         OPC_MADD:    data_in.grp = GRP_FUSED;
         OPC_MSUB:    data_in.grp = GRP_FUSED;
         OPC_NMSUB:   data_in.grp = GRP_FUSED;
         OPC_NMADD:   data_in.grp = GRP_FUSED;
         OPC_SYSTEM:  data_in.grp = GRP_SYSTEM;
         default:     data_in.grp = GRP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/rvdec_sub.sv =====
// Stage 2 of the decoder: match sub-codes to an instruction id and class and
// pick which fields the format uses. Depends on rvdec_pkg.
module rvdec_sub (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  rvdec_pkg::opc_type  in_data,
   output logic                out_valid,
   output rvdec_pkg::sub_type  out_data
);
   import rvdec_pkg::*;

   logic    valid_ff;
   sub_type data_ff;
   sub_type data_in;

   logic [31:0] w;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [4:0]  f5;
   logic [4:0]  rs2;

   assign w   = in_data.word;
   assign f3  = w[14:12];
   assign f7  = w[31:25];
   assign f5  = w[31:27];
   assign rs2 = w[24:20];

   always_comb begin
      data_in           = '0;
      data_in.word      = w;
      data_in.id        = ID_UNKNOWN;
      data_in.cls       = CLS_NONE;
      data_in.imm_sel   = IMM_NONE;
      case (in_data.grp)
         GRP_OP: begin
            data_in.cls     = CLS_R;
            data_in.use_rd  = 1'b1;
            data_in.use_rs1 = 1'b1;
            data_in.use_rs2 = 1'b1;
            if (f7 == F7_BASE) begin
               data_in.id = r_base_id(f3);
            end else if (f7 == F7_MULDIV) begin
               data_in.id = ID_MUL + 7'(f3);
            end else if (f7 == F7_ALT && f3 == F3_ADD) begin
               data_in.id = ID_SUB;
            end else if (f7 == F7_ALT && f3 == F3_SR) begin
               data_in.id = ID_SRA;
            end
         end
         GRP_OPIMM: begin
            data_in.cls     = CLS_I;
            data_in.use_rd  = 1'b1;
            data_in.use_rs1 = 1'b1;
            if (f3 inside {F3_SLL, F3_SR}) begin
               // unmatched shift keeps class I with no immediate
               if (f3 == F3_SLL && f7 == F7_BASE) begin
                  data_in.id = ID_SLLI;
               end else if (f3 == F3_SR && f7 == F7_BASE) begin
                  data_in.id = ID_SRLI;
               end else if (f3 == F3_SR && f7 == F7_ALT) begin
                  data_in.id = ID_SRAI;
               end
               if (data_in.id != ID_UNKNOWN) begin
                  data_in.cls       = CLS_SHIFT;
                  data_in.use_shamt = 1'b1;
               end
            end else begin
               data_in.id      = i_id(f3);
               data_in.imm_sel = IMM_I;
            end
         end
         GRP_STORE: begin
            data_in.cls     = CLS_S;
            data_in.use_rs1 = 1'b1;
            data_in.use_rs2 = 1'b1;
            data_in.imm_sel = IMM_S;
            data_in.id      = s_id(f3);
         end
         GRP_BRANCH: begin
            data_in.cls     = CLS_B;
            data_in.use_rs1 = 1'b1;
            data_in.use_rs2 = 1'b1;
            data_in.imm_sel = IMM_B;
            data_in.id      = b_id(f3);
         end
         GRP_JAL: begin
            data_in.id      = ID_JAL;
            data_in.cls     = CLS_J;
            data_in.use_rd  = 1'b1;
            data_in.imm_sel = IMM_J;
         end
         GRP_JALR: begin
            data_in.id      = ID_JALR;
            data_in.cls     = CLS_JALR;
            data_in.use_rd  = 1'b1;
            data_in.use_rs1 = 1'b1;
            data_in.imm_sel = IMM_I;
         end
         GRP_UPPER: begin
            data_in.id      = (w[6:0] == OPC_LUI) ? ID_LUI : ID_AUIPC;
            data_in.cls     = CLS_U;
            data_in.use_rd  = 1'b1;
            data_in.imm_sel = IMM_U;
         end
         GRP_LOAD: begin
            data_in.cls     = CLS_LOAD;
            data_in.use_rd  = 1'b1;
            data_in.use_rs1 = 1'b1;
            data_in.imm_sel = IMM_I;
            data_in.id      = ld_id(f3);
         end
         GRP_LOADFP: begin
            data_in.id      = ID_FLW;
            data_in.cls     = CLS_FPL;
            data_in.use_rd  = 1'b1;
            data_in.use_rs1 = 1'b1;
            data_in.imm_sel = IMM_I;
         end
         GRP_STOREFP: begin
            data_in.id      = ID_FSW;
            data_in.cls     = CLS_FPS;
            data_in.use_rs1 = 1'b1;
            data_in.use_rs2 = 1'b1;
            data_in.imm_sel = IMM_S;
         end
         GRP_OPFP: begin
            // registers and fmt come through even when the sub-code misses
            data_in.use_rd  = 1'b1;
            data_in.use_rs1 = 1'b1;
            data_in.use_rs2 = 1'b1;
            data_in.use_fmt = 1'b1;
            case (f5)
               F5_FADD: begin
                  data_in.id = ID_FADD; data_in.cls = CLS_FPA;
               end
               F5_FMUL: begin
                  data_in.id = ID_FMUL; data_in.cls = CLS_FPA;
               end
               F5_FSUB: begin
                  data_in.id = ID_FSUB; data_in.cls = CLS_FPA;
               end
               F5_FDIV: begin
                  data_in.id = ID_FDIV; data_in.cls = CLS_FPA;
               end
               F5_FSGNJ: begin
                  if (f3 inside {[3'd0:3'd2]}) begin
                     data_in.id = ID_FSGNJ + 7'(f3); data_in.cls = CLS_FPA;
                  end
               end
               F5_FSQRT: begin
                  data_in.id = ID_FSQRT; data_in.cls = CLS_FPR1;
               end
               F5_FMINMX: begin
                  if (f3 inside {[3'd0:3'd1]}) begin
                     data_in.id = ID_FMIN + 7'(f3); data_in.cls = CLS_FMINMAX;
                  end
               end
               F5_FCVTWS: begin
                  if (rs2 inside {[5'd0:5'd1]}) begin
                     data_in.id  = ID_FCVTWS + 7'(rs2[0]);
                     data_in.cls = CLS_FPCONVINT;
                  end
               end
               F5_FMVXW: begin
                  if (f3 inside {[3'd0:3'd1]}) begin
                     data_in.id = ID_FMVXW + 7'(f3); data_in.cls = CLS_FPCONVINT;
                  end
               end
               F5_FCVTSW: begin
                  if (rs2 inside {[5'd0:5'd1]}) begin
                     data_in.id  = ID_FCVTSW + 7'(rs2[0]);
                     data_in.cls = CLS_INTCONVFP;
                  end
               end
               F5_FMVWX: begin
                  data_in.id = ID_FMVWX; data_in.cls = CLS_INTCONVFP;
               end
               F5_FCMP: begin
                  // rm counts down from fle through flt to feq
                  if (f3 inside {[3'd0:3'd2]}) begin
                     data_in.id = ID_FLE - 7'(f3); data_in.cls = CLS_FPCONVINT;
                  end
               end
               default: begin
                  data_in.id = ID_UNKNOWN;
               end
            endcase
         end
         GRP_FUSED: begin
            data_in.id      = ID_FMADD + 7'(w[3:2]);
            data_in.cls     = CLS_FPR4;
            data_in.use_rd  = 1'b1;
            data_in.use_rs1 = 1'b1;
            data_in.use_rs2 = 1'b1;
            data_in.use_rs3 = 1'b1;
            data_in.use_fmt = 1'b1;
         end
         GRP_SYSTEM: begin
            data_in.cls = CLS_ENV;
            if (f3 == F3_PRIV) begin
               if (w[31:20] == F12_ECALL) begin
                  data_in.id = ID_ECALL;
               end else if (w[31:20] == F12_EBREAK) begin
                  data_in.id = ID_EBREAK;
               end
            end
         end
         default: begin
            data_in.id = ID_UNKNOWN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/rvdec_out.sv =====
// Stage 3 of the decoder: form the immediate, gate unused fields to zero and
// register the result. Depends on rvdec_pkg.
module rvdec_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  rvdec_pkg::sub_type  in_data,
   output logic                out_valid,
   output rvdec_pkg::rsp_type  out_data
);
   import rvdec_pkg::*;

   logic        valid_ff;
   rsp_type     data_ff;
   rsp_type     data_in;
   logic [31:0] w;
   logic [31:0] imm;

   assign w = in_data.word;

   always_comb begin
      case (in_data.imm_sel)
         IMM_I:   imm = {{20{w[31]}}, w[31:20]};
         IMM_S:   imm = {{20{w[31]}}, w[31:25], w[11:7]};
         IMM_B:   imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
         IMM_J:   imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
         IMM_U:   imm = {w[31:12], 12'h000};
         default: imm = 32'h0000_0000;
      endcase
   end

   always_comb begin
      data_in.op_id        = in_data.id;
      data_in.op_class     = in_data.cls;
      data_in.dest_reg     = in_data.use_rd    ? w[11:7]  : 5'd0;
      data_in.src1_reg     = in_data.use_rs1   ? w[19:15] : 5'd0;
      data_in.src2_reg     = in_data.use_rs2   ? w[24:20] : 5'd0;
      data_in.src3_reg     = in_data.use_rs3   ? w[31:27] : 5'd0;
      data_in.immediate    = $signed(imm);
      data_in.shift_amount = in_data.use_shamt ? w[24:20] : 5'd0;
      data_in.fp_format    = in_data.use_fmt   ? w[26:25] : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
